// ===== design/ps2mf_pkg.sv =====
// Package for the mouse packet framer FIFO: request codes, byte phases,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ps2mf_pkg;

  // request codes carried by in_req_type
  localparam logic [1:0] REQ_DATA   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;  // ignored: no state change, no word

  // bit 3 of the flags byte is always set by the mouse
  localparam logic [7:0] SYNC_MARK = 8'h08;

  // byte position inside a packet
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef struct packed {
    logic byte_en;    // a data byte is accepted
    logic pop_en;     // pop on non-empty FIFO: read slot, advance read pointer
    logic load_zero;  // load a result with zero payload (status, empty pop)
    logic load_pop;   // load a result from the RAM read data
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
  } dp_sts_t;

endpackage

// ===== design/ps2mf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ps2mf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ps2mf_ctrl.sv =====
// Controller: handshake, output valid and the pop read sequence.
// Depends on ps2mf_pkg.
`timescale 1ns / 1ps

module ps2mf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  output logic               out_valid,
  input  logic               out_ready,
  output ps2mf_pkg::dp_cmd_t cmd,
  input  ps2mf_pkg::dp_sts_t sts
);
  import ps2mf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_POP_RD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   resp_req;
  logic   acc;

  // requests that produce a word need a free output register
  assign resp_req = (in_req_type == REQ_POP) || (in_req_type == REQ_STATUS);
  assign in_ready = (state_r == S_IDLE) && (!resp_req || !out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd.byte_en   = acc && (in_req_type == REQ_DATA);
    cmd.pop_en    = acc && (in_req_type == REQ_POP) && !sts.empty;
    cmd.load_zero = acc && ((in_req_type == REQ_STATUS) ||
                            ((in_req_type == REQ_POP) && sts.empty));
    cmd.load_pop  = (state_r == S_POP_RD);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (cmd.pop_en) state_nxt = S_POP_RD;
      S_POP_RD: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
    if (cmd.load_zero || cmd.load_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_pop_rd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_RD |=> state_r == S_IDLE)
    else $error("pop read state held more than one cycle");

  a_pop_rd_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_RD |-> !out_valid_r)
    else $error("output register busy when pop data arrives");

  a_pop_enters_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_en |=> state_r == S_POP_RD)
    else $error("pop on non-empty FIFO did not start a read");

  a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_zero && cmd.load_pop))
    else $error("two result loads in one cycle");

endmodule

// ===== design/ps2mf_dp.sv =====
// Datapath: byte framer, FIFO pointers, packet RAM and output word register.
// Depends on ps2mf_pkg and ps2mf_ram.
`timescale 1ns / 1ps

module ps2mf_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ps2mf_pkg::dp_cmd_t cmd,
  output ps2mf_pkg::dp_sts_t sts,
  input  logic [7:0]         data_byte,
  output logic               got_packet,
  output logic [7:0]         flags_out,
  output logic signed [7:0]  dx_out,
  output logic signed [7:0]  dy_out,
  output logic               not_empty
);
  import ps2mf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    first_r, second_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_inc, rd_inc;
  logic          full, empty, we;
  logic [23:0]   rdata;

  logic              got_r;
  logic [7:0]        flags_r;
  logic signed [7:0] dx_r, dy_r;
  logic              nempty_r;

  assign wr_inc = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
  assign full   = (wr_inc == rd_ptr_r);   // one slot kept free
  assign empty  = (wr_ptr_r == rd_ptr_r);
  assign sts.empty = empty;

  assign we = cmd.byte_en && (phase_r == PH_THIRD) && !full;

  always_comb begin
    phase_nxt  = phase_r;
    wr_ptr_nxt = we ? wr_inc : wr_ptr_r;
    rd_ptr_nxt = cmd.pop_en ? rd_inc : rd_ptr_r;
    if (cmd.byte_en) begin
      unique case (phase_r)
        PH_SECOND: phase_nxt = PH_THIRD;
        PH_THIRD:  phase_nxt = PH_FIRST;
        default:   phase_nxt = ((data_byte & SYNC_MARK) != 8'h00) ? PH_SECOND : PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      first_r  <= '0;
      second_r <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (cmd.byte_en && (phase_r != PH_SECOND) && (phase_r != PH_THIRD) &&
          ((data_byte & SYNC_MARK) != 8'h00)) begin
        first_r <= data_byte;
      end
      if (cmd.byte_en && (phase_r == PH_SECOND)) begin
        second_r <= data_byte;
      end
    end
  end

  ps2mf_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_ptr_r),
    .wdata ({first_r, second_r, data_byte}),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  // output word register; read pointer already advanced when pop data lands
  always_ff @(posedge clk) begin
    if (cmd.load_zero) begin
      got_r    <= 1'b0;
      flags_r  <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      nempty_r <= !empty;
    end else if (cmd.load_pop) begin
      got_r    <= 1'b1;
      flags_r  <= rdata[23:16];
      dx_r     <= $signed(rdata[15:8]);
      dy_r     <= $signed(rdata[7:0]);
      nempty_r <= !empty;
    end
  end

  assign got_packet = got_r;
  assign flags_out  = flags_r;
  assign dx_out     = dx_r;
  assign dy_out     = dy_r;
  assign not_empty  = nempty_r;

  a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIRST) || (phase_r == PH_SECOND) || (phase_r == PH_THIRD))
    else $error("byte phase reached unused code");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_en && (phase_r == PH_THIRD) && full |=> $stable(wr_ptr_r))
    else $error("write pointer moved on full FIFO");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_en |-> !empty)
    else $error("pop issued on empty FIFO");

endmodule

// ===== design/ps2_mouse_packet_framer_fifo.sv =====
// Top level of the PS/2 mouse packet framer with packet FIFO.
// Depends on ps2mf_pkg, ps2mf_ctrl, ps2mf_dp, ps2mf_ram.
`timescale 1ns / 1ps
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+----------------
//  in      | in_req_type, in_data_byte               | input     | in_valid/in_ready
//  out     | out_got_packet, out_flags_out,          | output    | out_valid/out_ready
//          | out_dx_out, out_dy_out, out_not_empty   |           |
//
// Sequencing: a data byte, status query or pop on an empty FIFO completes when
//   accepted; a pop returning a packet also passes the pop-read state, set by the
//   registered packet RAM read port (accept issues the read, pop-read loads the word).
// Reset: rst_n synchronous active low; clears byte phase, captured bytes,
//   FIFO pointers and output valid. RAM contents are not cleared and need no pass.
// Stalls: a pending output word blocks only pop and status words until taken;
//   data bytes keep flowing meanwhile.
// Framing: a first byte must carry bit 3 set; otherwise it is dropped. A third
//   byte with the FIFO full (DEPTH-1 packets held) drops the packet.

module ps2_mouse_packet_framer_fifo #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_got_packet,
  output logic [7:0]        out_flags_out,
  output logic signed [7:0] out_dx_out,
  output logic signed [7:0] out_dy_out,
  output logic              out_not_empty
);
  import ps2mf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: accepts words, sequences the pop read
  ps2mf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // datapath: framer, pointers, packet RAM, output register
  ps2mf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (in_data_byte),
    .got_packet (out_got_packet),
    .flags_out  (out_flags_out),
    .dx_out     (out_dx_out),
    .dy_out     (out_dy_out),
    .not_empty  (out_not_empty)
  );

endmodule

// ===== verif/ps2mf_scoreboard.sv =====
// Scoreboard for the mouse packet framer FIFO: tracks framing and FIFO state
// from accepted input words and checks every output word. Depends on ps2mf_pkg.
`timescale 1ns / 1ps

module ps2mf_scoreboard #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_got_packet,
  input  logic [7:0]        out_flags_out,
  input  logic signed [7:0] out_dx_out,
  input  logic signed [7:0] out_dy_out,
  input  logic              out_not_empty,
  output int                fail_count,
  output int                pending_count
);
  import ps2mf_pkg::*;

  typedef struct packed {
    logic              got;
    logic [7:0]        flags;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic              not_empty;
  } mouse_report_t;

  mouse_report_t expected_reports[$];

  // shadow framing and FIFO state
  logic [1:0]  phase;
  logic [7:0]  flags_byte;
  logic [7:0]  dx_byte;
  logic [23:0] slots [DEPTH];
  int          wr_idx;
  int          rd_idx;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    phase         = PH_FIRST;
    flags_byte    = '0;
    dx_byte       = '0;
    wr_idx        = 0;
    rd_idx        = 0;
  end

  task automatic report_mismatch(input string what, input int seen, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, seen, want);
    fail_count++;
  endtask

  // advance the shadow state for one accepted word, queue any report it causes
  task automatic frame_word(input logic [1:0] req, input logic [7:0] data);
    mouse_report_t rep;
    int            nxt;
    rep = '0;
    case (req)
      REQ_DATA: begin
        case (phase)
          PH_SECOND: begin
            dx_byte = data;
            phase   = PH_THIRD;
          end
          PH_THIRD: begin
            phase = PH_FIRST;
            nxt   = (wr_idx + 1) % DEPTH;
            // full FIFO drops the packet
            if (nxt != rd_idx) begin
              slots[wr_idx] = {flags_byte, dx_byte, data};
              wr_idx        = nxt;
            end
          end
          default: begin
            if ((data & SYNC_MARK) != 8'h00) begin
              flags_byte = data;
              phase      = PH_SECOND;
            end else begin
              phase = PH_FIRST;
            end
          end
        endcase
      end
      REQ_POP: begin
        if (wr_idx != rd_idx) begin
          rep.got   = 1'b1;
          rep.flags = slots[rd_idx][23:16];
          rep.dx    = slots[rd_idx][15:8];
          rep.dy    = slots[rd_idx][7:0];
          rd_idx    = (rd_idx + 1) % DEPTH;
        end
        rep.not_empty = (wr_idx != rd_idx);
        expected_reports.push_back(rep);
      end
      REQ_STATUS: begin
        rep.not_empty = (wr_idx != rd_idx);
        expected_reports.push_back(rep);
      end
      default: ;  // unused code: ignored
    endcase
  endtask

  always @(posedge clk) begin
    mouse_report_t want;
    if (!rst_n) begin
      phase      = PH_FIRST;
      flags_byte = '0;
      dx_byte    = '0;
      wr_idx     = 0;
      rd_idx     = 0;
      expected_reports.delete();
    end else begin
      if (in_valid && in_ready) frame_word(in_req_type, in_data_byte);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected output word", 1, 0);
        end else begin
          want = expected_reports.pop_front();
          if (out_got_packet !== want.got)
            report_mismatch("got_packet", out_got_packet, want.got);
          if (out_flags_out !== want.flags)
            report_mismatch("flags_out", out_flags_out, want.flags);
          if (out_dx_out !== want.dx)
            report_mismatch("dx_out", out_dx_out, want.dx);
          if (out_dy_out !== want.dy)
            report_mismatch("dy_out", out_dy_out, want.dy);
          if (out_not_empty !== want.not_empty)
            report_mismatch("not_empty", out_not_empty, want.not_empty);
        end
      end
    end
    pending_count = expected_reports.size();
  end

endmodule

// ===== verif/ps2_mouse_packet_framer_fifo_tb.sv =====
// Testbench top for the mouse packet framer FIFO: clock, reset, stimulus,
// back-pressure and verdict. Depends on ps2mf_pkg, ps2mf_scoreboard and the block.
`timescale 1ns / 1ps

module ps2_mouse_packet_framer_fifo_tb;
  import ps2mf_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_WORDS   = 1700;
  // no accept on either side for this long means the block is hung;
  // longest legal quiet stretch is one sender gap plus one receiver stall
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [7:0]        in_data_byte;
  logic              out_valid;
  logic              out_ready;
  logic              out_got_packet;
  logic [7:0]        out_flags_out;
  logic signed [7:0] out_dx_out;
  logic signed [7:0] out_dy_out;
  logic              out_not_empty;

  int fail_count;
  int pending_count;
  int stall_cycles;
  int words_sent;
  bit no_gaps;  // stretches where the sender never idles

  ps2_mouse_packet_framer_fifo #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_got_packet (out_got_packet),
    .out_flags_out  (out_flags_out),
    .out_dx_out     (out_dx_out),
    .out_dy_out     (out_dy_out),
    .out_not_empty  (out_not_empty)
  );

  ps2mf_scoreboard #(.DEPTH(DEPTH)) scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_got_packet (out_got_packet),
    .out_flags_out  (out_flags_out),
    .out_dx_out     (out_dx_out),
    .out_dy_out     (out_dy_out),
    .out_not_empty  (out_not_empty),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: alternate ready runs and stalls, with the odd long ready run
  initial begin
    int hold;
    out_ready = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_ready) begin
        out_ready = 1'b0;
        hold      = pick_gap();
      end else begin
        out_ready = 1'b1;
        hold      = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // present one word at the falling edge and hold it until accepted;
  // valid stays high into the next word when there is no gap
  task automatic send_word(input logic [1:0] req, input logic [7:0] data);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_req_type  = req;
    in_data_byte = data;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
    words_sent++;
  endtask

  // three bytes; a pop or status word may slip in between
  task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                             input logic [7:0] dy, input int interleave_pct);
    logic [7:0] pkt [3];
    int         i;
    pkt[0] = flags;
    pkt[1] = dx;
    pkt[2] = dy;
    for (i = 0; i < 3; i++) begin
      send_word(REQ_DATA, pkt[i]);
      if (i < 2 && $urandom_range(0, 99) < interleave_pct)
        send_word($urandom_range(0, 1) ? REQ_POP : REQ_STATUS, 8'($urandom()));
    end
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    int  r;
    bit  filling;
    int  phase_left;
    int  next_pause;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_STATUS;
    in_data_byte = 8'h00;
    words_sent   = 0;
    no_gaps      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty FIFO, sync drop, unused code, extreme motion,
    // requests in the middle of a packet
    send_word(REQ_STATUS, 8'hFF);          // status on empty FIFO
    send_word(REQ_POP, 8'h00);             // pop on empty FIFO
    send_word(REQ_DATA, 8'h00);            // no sync bit: dropped
    send_word(REQ_DATA, 8'hF7);            // all bits but sync: dropped
    send_word(REQ_UNUSED, 8'hFF);          // unused code: ignored
    send_packet(8'h08, 8'h7F, 8'h80, 0);   // max +dx, min dy
    send_word(REQ_STATUS, 8'h00);
    send_packet(8'hFF, 8'h80, 8'h7F, 0);   // all flags, min dx, max dy
    send_word(REQ_POP, 8'hFF);
    send_word(REQ_POP, 8'h00);
    send_word(REQ_POP, 8'h00);             // empty again
    send_word(REQ_DATA, 8'h09);            // first byte
    send_word(REQ_POP, 8'h00);             // pop between bytes
    send_word(REQ_DATA, 8'h00);            // second byte: zero motion
    send_word(REQ_STATUS, 8'h55);
    send_word(REQ_DATA, 8'hFF);            // third byte: -1
    send_word(REQ_UNUSED, 8'h00);
    send_word(REQ_POP, 8'h00);
    send_word(REQ_STATUS, 8'h00);
    wait_for_drain();

    // random: alternating fill and drain phases so the FIFO hits full
    // (dropped packets) and empty; mostly well-formed packets
    filling    = 1'b1;
    phase_left = 0;
    next_pause = words_sent + 400;
    while (words_sent < RANDOM_WORDS) begin
      if (phase_left <= 0) begin
        filling    = ($urandom_range(0, 99) < 55);
        phase_left = $urandom_range(30, 160);
        no_gaps    = ($urandom_range(0, 3) == 0);
      end
      if (words_sent >= next_pause) begin
        // hold off until every outstanding report has come back
        wait_for_drain();
        next_pause = words_sent + 400;
      end
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 72)      send_packet(8'($urandom()) | SYNC_MARK, 8'($urandom()),
                                     8'($urandom()), 8);
        else if (r < 78) send_word(REQ_DATA, 8'($urandom()) & ~SYNC_MARK);
        else if (r < 82) send_word(REQ_DATA, 8'($urandom()));  // stray byte
        else if (r < 90) send_word(REQ_STATUS, 8'($urandom()));
        else if (r < 95) send_word(REQ_POP, 8'($urandom()));
        else             send_word(REQ_UNUSED, 8'($urandom()));
      end else begin
        if (r < 50)      send_word(REQ_POP, 8'($urandom()));
        else if (r < 70) send_packet(8'($urandom()) | SYNC_MARK, 8'($urandom()),
                                     8'($urandom()), 15);
        else if (r < 85) send_word(REQ_STATUS, 8'($urandom()));
        else if (r < 95) send_word(REQ_DATA, 8'($urandom()));
        else             send_word(REQ_UNUSED, 8'($urandom()));
      end
      phase_left--;
    end

    // drain: pops until empty are covered by the scoreboard; wait for the tail
    no_gaps = 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
